>>> src/cbspe_pkg.sv
// ---------------------------------------------------------------------------
// cbspe_pkg: shared types and constants for the cubic B-spline patch core
// Default patch, weight arithmetic constants, queue depth, command types.
// ---------------------------------------------------------------------------
package cbspe_pkg;

   localparam int PARAM_FRAC_BITS_DEF = 16;
   localparam int COORD_WIDTH_DEF     = 24;

   localparam int NUM_LANES  = 3;
   localparam int NUM_PTS    = 16;
   localparam int T_WIDTH    = 17;
   localparam int W_WIDTH    = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [T_WIDTH-1:0] Q16_ONE = 17'h10000;

   // floor(q / 6) == (q * RECIP_6) >> RECIP_SHIFT for q < 2**21
   localparam logic [19:0] RECIP_6     = 20'd699051;
   localparam int          RECIP_SHIFT = 22;

   localparam int DFLT_SCALE = 256;
   localparam int DFLT_PATCH [NUM_LANES][NUM_PTS] = '{
      '{ 20, 0, -130, -250, 100, 30, -40, -110, 280, 110, 0, -100, 350, 200, 50, 0 },
      '{ 0, 100, 100, 50, 100, 100, 100, 50, 90, 120, 130, 150, 30, 150, 200, 100 },
      '{ 200, 150, 50, 0, 150, 100, 50, 0, 140, 80, 30, -50, 150, 50, 0, -70 }
   };

   typedef enum logic {
      FUNC_LOAD = 1'b0,
      FUNC_EVAL = 1'b1
   } func_type;

   typedef struct packed {
      logic       is_eval;
      logic [3:0] idx;
   } cmd_ctl_type;

   typedef logic [3:0][W_WIDTH-1:0] weight_set_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_WAIT_W,
      BK_RUN,
      BK_DRAIN,
      BK_FIN
   } back_state_type;

endpackage

>>> src/cbspe_front.sv
// ---------------------------------------------------------------------------
// cbspe_front: request intake
// Accepts requests, splits load from evaluate and brings u and v to Q1.16.
// ---------------------------------------------------------------------------
module cbspe_front #(
   parameter int PARAM_FRAC_BITS = cbspe_pkg::PARAM_FRAC_BITS_DEF,
   parameter int COORD_WIDTH     = cbspe_pkg::COORD_WIDTH_DEF
) (
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic [1:0]                          req_row,
   input  logic [1:0]                          req_col,
   input  logic signed [COORD_WIDTH-1:0]       req_coord_x,
   input  logic signed [COORD_WIDTH-1:0]       req_coord_y,
   input  logic signed [COORD_WIDTH-1:0]       req_coord_z,
   input  logic [PARAM_FRAC_BITS:0]            req_u_param,
   input  logic [PARAM_FRAC_BITS:0]            req_v_param,
   input  logic                                q_full,
   output logic                                push,
   output cbspe_pkg::cmd_ctl_type              push_ctl,
   output logic signed [COORD_WIDTH-1:0]       push_x,
   output logic signed [COORD_WIDTH-1:0]       push_y,
   output logic signed [COORD_WIDTH-1:0]       push_z,
   output logic [cbspe_pkg::T_WIDTH-1:0]       push_tu,
   output logic [cbspe_pkg::T_WIDTH-1:0]       push_tv
);

   localparam int PW = PARAM_FRAC_BITS + 1;
   localparam logic [PW-1:0] P_ONE = {1'b1, {PARAM_FRAC_BITS{1'b0}}};

   logic [PW-1:0] u_sat;
   logic [PW-1:0] v_sat;

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   assign push_ctl.is_eval = (req_func == cbspe_pkg::FUNC_EVAL);
   assign push_ctl.idx     = {req_row, req_col};
   assign push_x = req_coord_x;
   assign push_y = req_coord_y;
   assign push_z = req_coord_z;

   assign u_sat = (req_u_param > P_ONE) ? P_ONE : req_u_param;
   assign v_sat = (req_v_param > P_ONE) ? P_ONE : req_v_param;

   generate
      if (PARAM_FRAC_BITS > 16) begin : g_narrow
         localparam int SH = PARAM_FRAC_BITS - 16;
         localparam logic [PW:0] HALF = (PW+1)'(1) << (SH - 1);
         logic [PW:0] u_rnd;
         logic [PW:0] v_rnd;
         assign u_rnd   = {1'b0, u_sat} + HALF;
         assign v_rnd   = {1'b0, v_sat} + HALF;
         assign push_tu = u_rnd[SH +: cbspe_pkg::T_WIDTH];
         assign push_tv = v_rnd[SH +: cbspe_pkg::T_WIDTH];
      end else if (PARAM_FRAC_BITS == 16) begin : g_same
         assign push_tu = u_sat;
         assign push_tv = v_sat;
      end else begin : g_widen
         assign push_tu = {u_sat, {(16 - PARAM_FRAC_BITS){1'b0}}};
         assign push_tv = {v_sat, {(16 - PARAM_FRAC_BITS){1'b0}}};
      end
   endgenerate

endmodule

>>> src/cbspe_queue.sv
// ---------------------------------------------------------------------------
// cbspe_queue: command queue
// Short FIFO between request intake and the evaluation engine.
// ---------------------------------------------------------------------------
module cbspe_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data
);

   localparam int AW = (cbspe_pkg::QUEUE_DEPTH > 1) ? $clog2(cbspe_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(cbspe_pkg::QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(cbspe_pkg::QUEUE_DEPTH);
   localparam logic [AW-1:0] LAST_C  = AW'(cbspe_pkg::QUEUE_DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [cbspe_pkg::QUEUE_DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_pop;

   assign full      = (count_ff == DEPTH_C);
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_C) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_C) ? '0 : rd_ptr_ff + AW'(1);
      end
      case ({push, do_pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/cbspe_basis.sv
// ---------------------------------------------------------------------------
// cbspe_basis: uniform cubic B-spline basis weights
// Five-stage pipeline from a Q1.16 parameter to four Q0.16 weights.
// ---------------------------------------------------------------------------
module cbspe_basis (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [cbspe_pkg::T_WIDTH-1:0]   t_in,
   output logic                            done,
   output cbspe_pkg::weight_set_type       weights
);

   localparam int TW = cbspe_pkg::T_WIDTH;

   logic [4:0]        vld_ff;
   logic [TW-1:0]     ta_ff, ma_ff, tb_ff, mb_ff, tc_ff;
   logic [2*TW-1:0]   sq_ff, msq_ff, sqc_ff;
   logic [3*TW-1:0]   cu_ff, mcu_ff;
   logic [19:0]       q_ff [4];
   logic [19:0]       q_in [4];
   logic [53:0]       b_val [4];
   logic [53:0]       t1e, t2e, t3e;
   logic [39:0]       prod [4];
   cbspe_pkg::weight_set_type w_ff;

   assign done    = vld_ff[4];
   assign weights = w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[3:0], start};
      end
   end

   assign t1e = 54'(tc_ff);
   assign t2e = 54'(sqc_ff);
   assign t3e = 54'(cu_ff);

   always_comb begin
      b_val[0] = 54'(mcu_ff);
      b_val[1] = 54'd3 * t3e - 54'd6 * (t2e << 16) + (54'd1 << 50);
      b_val[2] = 54'd3 * (t2e << 16) + 54'd3 * (t1e << 32) + (54'd1 << 48) - 54'd3 * t3e;
      b_val[3] = t3e;
      for (int i = 0; i < 4; i++) begin
         q_in[i] = b_val[i][51:32] + 20'd3;
         prod[i] = q_ff[i] * cbspe_pkg::RECIP_6;
      end
   end

   always_ff @(posedge clock) begin
      ta_ff  <= t_in;
      ma_ff  <= cbspe_pkg::Q16_ONE - t_in;
      sq_ff  <= ta_ff * ta_ff;
      msq_ff <= ma_ff * ma_ff;
      tb_ff  <= ta_ff;
      mb_ff  <= ma_ff;
      cu_ff  <= sq_ff * tb_ff;
      mcu_ff <= msq_ff * mb_ff;
      sqc_ff <= sq_ff;
      tc_ff  <= tb_ff;
      q_ff   <= q_in;
      if (vld_ff[3]) begin
         for (int i = 0; i < 4; i++) begin
            w_ff[i] <= prod[i][cbspe_pkg::RECIP_SHIFT +: cbspe_pkg::W_WIDTH];
         end
      end
   end

endmodule

>>> src/cbspe_back.sv
// ---------------------------------------------------------------------------
// cbspe_back: evaluation engine
// Control point store, tensor-product multiply-accumulate and result register.
// ---------------------------------------------------------------------------
module cbspe_back #(
   parameter int COORD_WIDTH = cbspe_pkg::COORD_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   output logic                               q_pop,
   input  cbspe_pkg::cmd_ctl_type             q_ctl,
   input  logic signed [COORD_WIDTH-1:0]      q_x,
   input  logic signed [COORD_WIDTH-1:0]      q_y,
   input  logic signed [COORD_WIDTH-1:0]      q_z,
   input  logic [cbspe_pkg::T_WIDTH-1:0]      q_tu,
   input  logic [cbspe_pkg::T_WIDTH-1:0]      q_tv,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [COORD_WIDTH-1:0]      rsp_point_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_point_y,
   output logic signed [COORD_WIDTH-1:0]      rsp_point_z
);

   localparam int NL  = cbspe_pkg::NUM_LANES;
   localparam int CW  = COORD_WIDTH;
   localparam int P1W = CW + 17;
   localparam int RW  = P1W + 2;
   localparam int RRW = RW - 8;
   localparam int P2W = RRW + 17;
   localparam int AW  = P2W + 2;
   localparam int FW  = AW - 24;
   localparam logic signed [RW-1:0] R_INIT   = RW'(128);
   localparam logic signed [AW-1:0] ACC_INIT = AW'(1) << 23;
   localparam logic signed [CW-1:0] OUT_MAX  = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] OUT_MIN  = {1'b1, {(CW-1){1'b0}}};

   cbspe_pkg::back_state_type state_ff, state_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic         start_w;
   logic         wu_done, wv_done;
   cbspe_pkg::weight_set_type wu, wv;
   logic         out_free;
   logic         load_out;

   logic signed [CW-1:0]  st_ff [NL][cbspe_pkg::NUM_PTS];
   logic signed [CW-1:0]  ld_pt [NL];

   logic         s1_vld_ff, rr_vld_ff, p2_vld_ff, acc_done_ff;
   logic [1:0]   s1_col_ff, s1_row_ff, rr_row_ff, p2_row_ff;
   logic signed [P1W-1:0] p1_ff  [NL];
   logic signed [RW-1:0]  r_ff   [NL];
   logic signed [RRW-1:0] rr_ff  [NL];
   logic signed [P2W-1:0] p2_ff  [NL];
   logic signed [AW-1:0]  acc_ff [NL];
   logic signed [CW-1:0]  res_in [NL];
   logic signed [CW-1:0]  out_ff [NL];
   logic                  rsp_valid_ff;

   assign ld_pt[0] = q_x;
   assign ld_pt[1] = q_y;
   assign ld_pt[2] = q_z;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   cbspe_basis u_basis_u (
      .clock   (clock),
      .reset   (reset),
      .start   (start_w),
      .t_in    (q_tu),
      .done    (wu_done),
      .weights (wu)
   );

   cbspe_basis u_basis_v (
      .clock   (clock),
      .reset   (reset),
      .start   (start_w),
      .t_in    (q_tv),
      .done    (wv_done),
      .weights (wv)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      q_pop    = 1'b0;
      start_w  = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         cbspe_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_ctl.is_eval) begin
                  start_w  = 1'b1;
                  state_in = cbspe_pkg::BK_WAIT_W;
               end
            end
         end
         cbspe_pkg::BK_WAIT_W: begin
            if (wu_done && wv_done) begin
               cnt_in   = '0;
               state_in = cbspe_pkg::BK_RUN;
            end
         end
         cbspe_pkg::BK_RUN: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               state_in = cbspe_pkg::BK_DRAIN;
            end
         end
         cbspe_pkg::BK_DRAIN: begin
            if (acc_done_ff) begin
               state_in = cbspe_pkg::BK_FIN;
            end
         end
         cbspe_pkg::BK_FIN: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = cbspe_pkg::BK_IDLE;
            end
         end
         default: state_in = cbspe_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cbspe_pkg::BK_IDLE;
         cnt_ff       <= '0;
         s1_vld_ff    <= 1'b0;
         rr_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         acc_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         s1_vld_ff   <= (state_ff == cbspe_pkg::BK_RUN);
         rr_vld_ff   <= s1_vld_ff && (s1_col_ff == 2'd3);
         p2_vld_ff   <= rr_vld_ff;
         acc_done_ff <= p2_vld_ff && (p2_row_ff == 2'd3);
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // control point store, reset to the default patch
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NL; c++) begin
            for (int i = 0; i < cbspe_pkg::NUM_PTS; i++) begin
               st_ff[c][i] <= CW'(cbspe_pkg::DFLT_PATCH[c][i] * cbspe_pkg::DFLT_SCALE);
            end
         end
      end else if (q_pop && !q_ctl.is_eval) begin
         for (int c = 0; c < NL; c++) begin
            st_ff[c][q_ctl.idx] <= ld_pt[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_col_ff <= cnt_ff[1:0];
      s1_row_ff <= cnt_ff[3:2];
      rr_row_ff <= s1_row_ff;
      p2_row_ff <= rr_row_ff;
   end

   generate
      for (genvar c = 0; c < NL; c++) begin : g_lane
         logic signed [RW-1:0]  r_sum;
         logic signed [AW-1:0]  acc_sum;
         logic signed [FW-1:0]  fin;
         logic signed [16:0]    wv_s, wu_s;

         assign wv_s    = $signed({1'b0, wv[cnt_ff[1:0]]});
         assign wu_s    = $signed({1'b0, wu[rr_row_ff]});
         assign r_sum   = ((s1_col_ff == 2'd0) ? R_INIT : r_ff[c]) + RW'(p1_ff[c]);
         assign acc_sum = ((p2_row_ff == 2'd0) ? ACC_INIT : acc_ff[c]) + AW'(p2_ff[c]);
         assign fin     = acc_ff[c][AW-1:24];

         always_comb begin
            if ((&fin[FW-1:CW-1]) || !(|fin[FW-1:CW-1])) begin
               res_in[c] = fin[CW-1:0];
            end else begin
               res_in[c] = fin[FW-1] ? OUT_MIN : OUT_MAX;
            end
         end

         always_ff @(posedge clock) begin
            p1_ff[c] <= st_ff[c][cnt_ff] * wv_s;
            if (s1_vld_ff) begin
               r_ff[c] <= r_sum;
               if (s1_col_ff == 2'd3) begin
                  rr_ff[c] <= r_sum[RW-1:8];
               end
            end
            p2_ff[c] <= rr_ff[c] * wu_s;
            if (p2_vld_ff) begin
               acc_ff[c] <= acc_sum;
            end
            if (load_out) begin
               out_ff[c] <= res_in[c];
            end
         end
      end
   endgenerate

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_point_x = out_ff[0];
   assign rsp_point_y = out_ff[1];
   assign rsp_point_z = out_ff[2];

endmodule

>>> src/cubic_bspline_patch_eval_core.sv
// An evaluate request runs through the 5-stage basis pipelines, the start of the
// sweep, the multiply-accumulate sweep over the 16 control points and a drain before
// its result is registered; the engine takes a new evaluate only once the last result
// is loaded, which waits while the output stalls. A load is stored without leaving idle.
// A 2-entry queue keeps intake open while the engine works, until the queue fills.
// Reset: synchronous; the control point store returns to the default patch.
// ---------------------------------------------------------------------------
// cubic_bspline_patch_eval_core: uniform cubic B-spline surface patch evaluator
// Loads 4x4 control points and evaluates surface points at (u, v).
// ---------------------------------------------------------------------------
module cubic_bspline_patch_eval_core #(
   parameter int PARAM_FRAC_BITS = cbspe_pkg::PARAM_FRAC_BITS_DEF,
   parameter int COORD_WIDTH     = cbspe_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [1:0]                    req_row,
   input  logic [1:0]                    req_col,
   input  logic signed [COORD_WIDTH-1:0] req_coord_x,
   input  logic signed [COORD_WIDTH-1:0] req_coord_y,
   input  logic signed [COORD_WIDTH-1:0] req_coord_z,
   input  logic [PARAM_FRAC_BITS:0]      req_u_param,
   input  logic [PARAM_FRAC_BITS:0]      req_v_param,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_point_x,
   output logic signed [COORD_WIDTH-1:0] rsp_point_y,
   output logic signed [COORD_WIDTH-1:0] rsp_point_z
);

   localparam int TW = cbspe_pkg::T_WIDTH;
   localparam int QW = $bits(cbspe_pkg::cmd_ctl_type) + 3 * COORD_WIDTH + 2 * TW;

   logic                          push, q_full, q_valid, q_pop;
   cbspe_pkg::cmd_ctl_type        push_ctl, q_ctl;
   logic signed [COORD_WIDTH-1:0] push_x, push_y, push_z;
   logic signed [COORD_WIDTH-1:0] q_x, q_y, q_z;
   logic [TW-1:0]                 push_tu, push_tv, q_tu, q_tv;
   logic [QW-1:0]                 q_wdata, q_rdata;

   cbspe_front #(
      .PARAM_FRAC_BITS (PARAM_FRAC_BITS),
      .COORD_WIDTH     (COORD_WIDTH)
   ) u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_row     (req_row),
      .req_col     (req_col),
      .req_coord_x (req_coord_x),
      .req_coord_y (req_coord_y),
      .req_coord_z (req_coord_z),
      .req_u_param (req_u_param),
      .req_v_param (req_v_param),
      .q_full      (q_full),
      .push        (push),
      .push_ctl    (push_ctl),
      .push_x      (push_x),
      .push_y      (push_y),
      .push_z      (push_z),
      .push_tu     (push_tu),
      .push_tv     (push_tv)
   );

   assign q_wdata = {push_ctl, push_x, push_y, push_z, push_tu, push_tv};
   assign {q_ctl, q_x, q_y, q_z, q_tu, q_tv} = q_rdata;

   cbspe_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .out_valid (q_valid),
      .out_data  (q_rdata)
   );

   cbspe_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_ctl       (q_ctl),
      .q_x         (q_x),
      .q_y         (q_y),
      .q_z         (q_z),
      .q_tu        (q_tu),
      .q_tv        (q_tv),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_point_x (rsp_point_x),
      .rsp_point_y (rsp_point_y),
      .rsp_point_z (rsp_point_z)
   );

endmodule

>>> test/cbspe_surface_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// cbspe_surface_checker: scoreboard for the cubic B-spline patch core
// Monitors both handshake channels, keeps a shadow copy of the 4x4 control
// point grid, predicts each evaluated surface point in fixed point and checks
// every returned point field by field, in order.
// ---------------------------------------------------------------------------
module cbspe_surface_checker #(
   parameter int CW = cbspe_pkg::COORD_WIDTH_DEF,
   parameter int PW = cbspe_pkg::PARAM_FRAC_BITS_DEF + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 req_func,
   input  logic [1:0]           req_row,
   input  logic [1:0]           req_col,
   input  logic signed [CW-1:0] req_coord_x,
   input  logic signed [CW-1:0] req_coord_y,
   input  logic signed [CW-1:0] req_coord_z,
   input  logic [PW-1:0]        req_u_param,
   input  logic [PW-1:0]        req_v_param,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic signed [CW-1:0] rsp_point_x,
   input  logic signed [CW-1:0] rsp_point_y,
   input  logic signed [CW-1:0] rsp_point_z,
   output int                   fail_count,
   output int                   pending
);

   localparam longint SPAN   = 65536;
   localparam longint W_DEN  = longint'(6) << 32;
   localparam longint W_HALF = longint'(3) << 32;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } surf_point_type;

   typedef logic [3:0][16:0] basis_set_type;

   logic signed [CW-1:0] ctrl_pt [cbspe_pkg::NUM_LANES][cbspe_pkg::NUM_PTS];
   surf_point_type       surface_pts[$];
   int                   fails = 0;
   int                   waiting = 0;

   assign fail_count = fails;
   assign pending    = waiting;

   // four uniform cubic basis weights, Q0.16, parameter saturated at 1.0
   function automatic basis_set_type spline_weights(input logic [PW-1:0] raw);
      longint        t, t2, t3, m, s3;
      longint        b0, b1, b2, b3;
      basis_set_type w;
      t  = (raw > cbspe_pkg::Q16_ONE) ? SPAN : longint'(raw);
      t2 = t * t;
      t3 = t2 * t;
      s3 = SPAN * SPAN * SPAN;
      m  = SPAN - t;
      b0 = m * m * m;
      b1 = 3 * t3 - 6 * t2 * SPAN + 4 * s3;
      b2 = -3 * t3 + 3 * t2 * SPAN + 3 * t * SPAN * SPAN + s3;
      b3 = t3;
      w[0] = 17'((b0 + W_HALF) / W_DEN);
      w[1] = 17'((b1 + W_HALF) / W_DEN);
      w[2] = 17'((b2 + W_HALF) / W_DEN);
      w[3] = 17'((b3 + W_HALF) / W_DEN);
      return w;
   endfunction

   function automatic logic signed [CW-1:0] blend_lane(input int lane,
                                                       input basis_set_type wu,
                                                       input basis_set_type wv);
      longint acc, row_sum, hi, lo;
      acc = 0;
      for (int i = 0; i < 4; i++) begin
         row_sum = 0;
         for (int j = 0; j < 4; j++)
            row_sum += longint'(ctrl_pt[lane][i*4+j]) * longint'(wv[j]);
         acc += ((row_sum + 128) >>> 8) * longint'(wu[i]);
      end
      acc = (acc + (longint'(1) << 23)) >>> 24;
      hi  = (longint'(1) << (CW - 1)) - 1;
      lo  = -hi - 1;
      if (acc > hi) acc = hi;
      if (acc < lo) acc = lo;
      return CW'(acc);
   endfunction

   task automatic flag_field(input string what, input logic signed [CW-1:0] want,
                             input logic signed [CW-1:0] got);
      fails++;
      if (fails <= 10)
         $display("checker: %s mismatch at %0t: expected %0d, got %0d",
                  what, $realtime, want, got);
   endtask

   always @(posedge clock) begin
      basis_set_type  wu, wv;
      surf_point_type want;
      if (reset) begin
         for (int l = 0; l < cbspe_pkg::NUM_LANES; l++)
            for (int i = 0; i < cbspe_pkg::NUM_PTS; i++)
               ctrl_pt[l][i] = CW'(cbspe_pkg::DFLT_PATCH[l][i] * cbspe_pkg::DFLT_SCALE);
         surface_pts.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (surface_pts.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("checker: unexpected point at %0t: %0d %0d %0d",
                           $realtime, rsp_point_x, rsp_point_y, rsp_point_z);
            end else begin
               want = surface_pts.pop_front();
               if (rsp_point_x !== want.x) flag_field("point_x", want.x, rsp_point_x);
               if (rsp_point_y !== want.y) flag_field("point_y", want.y, rsp_point_y);
               if (rsp_point_z !== want.z) flag_field("point_z", want.z, rsp_point_z);
            end
         end
         if (req_valid && !req_stall) begin
            if (req_func == cbspe_pkg::FUNC_EVAL) begin
               wu = spline_weights(req_u_param);
               wv = spline_weights(req_v_param);
               want.x = blend_lane(0, wu, wv);
               want.y = blend_lane(1, wu, wv);
               want.z = blend_lane(2, wu, wv);
               surface_pts.push_back(want);
            end else begin
               ctrl_pt[0][{req_row, req_col}] = req_coord_x;
               ctrl_pt[1][{req_row, req_col}] = req_coord_y;
               ctrl_pt[2][{req_row, req_col}] = req_coord_z;
            end
         end
      end
      waiting = surface_pts.size();
   end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: testbench for cubic_bspline_patch_eval_core
// Drives control point loads and surface evaluations under three mixes of
// sender gaps and receiver stalls; a separate checker predicts and compares.
// ---------------------------------------------------------------------------
module tb;

   localparam int CW           = cbspe_pkg::COORD_WIDTH_DEF;
   localparam int PW           = cbspe_pkg::PARAM_FRAC_BITS_DEF + 1;
   localparam int PHASE_ITEMS  = 450;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 60;

   localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_func = cbspe_pkg::FUNC_LOAD;
   logic [1:0]           req_row = '0;
   logic [1:0]           req_col = '0;
   logic signed [CW-1:0] req_coord_x = '0;
   logic signed [CW-1:0] req_coord_y = '0;
   logic signed [CW-1:0] req_coord_z = '0;
   logic [PW-1:0]        req_u_param = '0;
   logic [PW-1:0]        req_v_param = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic signed [CW-1:0] rsp_point_x;
   logic signed [CW-1:0] rsp_point_y;
   logic signed [CW-1:0] rsp_point_z;

   int fail_count;
   int pending;
   int gap_pct = 31;
   int stall_pct = 61;
   int loads_sent = 0;
   int evals_sent = 0;
   int cycle_count = 0;

   cubic_bspline_patch_eval_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_row     (req_row),
      .req_col     (req_col),
      .req_coord_x (req_coord_x),
      .req_coord_y (req_coord_y),
      .req_coord_z (req_coord_z),
      .req_u_param (req_u_param),
      .req_v_param (req_v_param),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_point_x (rsp_point_x),
      .rsp_point_y (rsp_point_y),
      .rsp_point_z (rsp_point_z)
   );

   cbspe_surface_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_row     (req_row),
      .req_col     (req_col),
      .req_coord_x (req_coord_x),
      .req_coord_y (req_coord_y),
      .req_coord_z (req_coord_z),
      .req_u_param (req_u_param),
      .req_v_param (req_v_param),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_point_x (rsp_point_x),
      .rsp_point_y (rsp_point_y),
      .rsp_point_z (rsp_point_z),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic put_req(input cbspe_pkg::func_type f, input logic [1:0] r,
                          input logic [1:0] c,
                          input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                          input logic signed [CW-1:0] z, input logic [PW-1:0] u,
                          input logic [PW-1:0] v);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= f;
      req_row     <= r;
      req_col     <= c;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      req_u_param <= u;
      req_v_param <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (f == cbspe_pkg::FUNC_EVAL) evals_sent++;
      else loads_sent++;
   endtask

   task automatic load_pt(input logic [1:0] r, input logic [1:0] c,
                          input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                          input logic signed [CW-1:0] z);
      put_req(cbspe_pkg::FUNC_LOAD, r, c, x, y, z, PW'($urandom), PW'($urandom));
   endtask

   task automatic eval_at(input logic [PW-1:0] u, input logic [PW-1:0] v);
      put_req(cbspe_pkg::FUNC_EVAL, 2'($urandom), 2'($urandom), CW'($urandom),
              CW'($urandom), CW'($urandom), u, v);
   endtask

   function automatic logic signed [CW-1:0] rand_coord();
      case ($urandom_range(9))
         0:       return C_MAX;
         1:       return C_MIN;
         2, 3:    return CW'($signed($urandom_range(131071)) - 65536);
         default: return CW'($urandom);
      endcase
   endfunction

   function automatic logic [PW-1:0] rand_param();
      case ($urandom_range(9))
         0:       return '0;
         1:       return PW'(cbspe_pkg::Q16_ONE);
         2:       return PW'($urandom_range(131071, 65537));
         3:       return PW'($urandom_range(255));
         default: return PW'($urandom_range(65536));
      endcase
   endfunction

   // full grid rewrites followed by evaluate bursts, stray loads and, most often, bare evaluate bursts
   task automatic random_phase(input int n);
      int start, kind, burst;
      logic signed [CW-1:0] cx, cy, cz;
      start = loads_sent + evals_sent;
      while (loads_sent + evals_sent - start < n) begin
         case ($urandom_range(9))
            0, 1, 2: begin
               kind = $urandom_range(3);
               for (int i = 0; i < cbspe_pkg::NUM_PTS; i++) begin
                  case (kind)
                     0:       begin cx = C_MAX; cy = C_MAX; cz = C_MAX; end
                     1:       begin cx = C_MIN; cy = C_MIN; cz = C_MIN; end
                     2:       begin cx = rand_coord(); cy = rand_coord(); cz = rand_coord(); end
                     default: begin
                        cx = CW'($signed($urandom_range(8191)) - 4096);
                        cy = CW'($signed($urandom_range(8191)) - 4096);
                        cz = CW'($signed($urandom_range(8191)) - 4096);
                     end
                  endcase
                  load_pt(2'(i / 4), 2'(i % 4), cx, cy, cz);
               end
               burst = $urandom_range(8, 2);
               repeat (burst) eval_at(rand_param(), rand_param());
            end
            3:
               load_pt(2'($urandom), 2'($urandom), rand_coord(), rand_coord(), rand_coord());
            default: begin
               burst = $urandom_range(4, 1);
               repeat (burst) eval_at(rand_param(), rand_param());
            end
         endcase
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default patch, corners and saturated parameters
      eval_at('0, '0);
      eval_at(PW'(cbspe_pkg::Q16_ONE), PW'(cbspe_pkg::Q16_ONE));
      eval_at(PW'(32768), PW'(16384));
      eval_at({PW{1'b1}}, '0);
      eval_at(PW'(1), PW'(65535));
      eval_at(PW'(65537), PW'(98304));
      // extreme grid around the origin corner, pushes rounding against the clamp
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            load_pt(2'(r), 2'(c), C_MAX, C_MIN, -1);
      eval_at('0, '0);
      load_pt(2'd3, 2'd3, C_MIN, C_MAX, CW'(1));
      eval_at(PW'(cbspe_pkg::Q16_ONE), PW'(cbspe_pkg::Q16_ONE));
      random_phase(PHASE_ITEMS);

      gap_pct   = 61;
      stall_pct = 31;
      random_phase(PHASE_ITEMS);

      gap_pct   = 0;
      stall_pct = 0;
      random_phase(PHASE_ITEMS);

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("tb: %0d control point loads and %0d surface evaluations over three",
               loads_sent, evals_sent);
      $display("tb: gap/stall mixes, %0d field mismatches or stray points", fail_count);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

>>> sim.f
src/cbspe_pkg.sv
src/cbspe_front.sv
src/cbspe_queue.sv
src/cbspe_basis.sv
src/cbspe_back.sv
src/cubic_bspline_patch_eval_core.sv
test/cbspe_surface_checker.sv
test/tb.sv
